// File: hw/rtl/acfc_pkg.sv
// shared types and constants for the armed channel firing controller
// no dependencies; imported by the interfaces and every rtl module
package acfc_pkg;

	// default channel count for the top level parameter
	localparam int NUM_CHANNELS_DEF = 8;

	// payload field widths
	localparam int OP_W    = 3;
	localparam int TIME_W  = 32;
	localparam int MASK_W  = 8;
	localparam int SEL_W   = 3;
	localparam int TICKS_W = 16;
	localparam int WIN_W   = 8;
	localparam int PHASE_W = 10;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDENT_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW = 2'd2;

	// register reset values
	localparam logic [TICKS_W-1:0] PULSE_TICKS_RST = 16'd1000;
	localparam logic [TICKS_W-1:0] IDENT_TICKS_RST = 16'd2000;
	localparam logic [WIN_W-1:0]   TIME_WINDOW_RST = 8'd5;

	// last millisecond phase of a second
	localparam logic [PHASE_W-1:0] PHASE_LAST = 10'd999;

	// item operation codes
	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_ARM      = 3'd1,
		OP_DISARM   = 3'd2,
		OP_RATE_LO  = 3'd3,
		OP_RATE_HI  = 3'd4,
		OP_IDENTIFY = 3'd5,
		OP_PING     = 3'd6,
		OP_FIRE     = 3'd7
	} acfc_op_t;

	// per-channel control from the core to a channel lane
	typedef struct packed {
		logic               tick;
		logic               fire;
		logic [TICKS_W-1:0] len;
		logic [TIME_W-1:0]  stamp;
	} acfc_lane_ctl_t;

	// a zero length counts as one tick
	function automatic logic [TICKS_W-1:0] at_least_one(input logic [TICKS_W-1:0] v);
		at_least_one = (v == '0) ? TICKS_W'(1) : v;
	endfunction

endpackage

// File: hw/rtl/acfc_if.sv
// handshake interfaces: command items in, result items out, register writes
// depends on acfc_pkg for field widths
interface acfc_item_if import acfc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [TIME_W-1:0] cmd_time;
	logic [MASK_W-1:0] channels;
	logic [SEL_W-1:0]  status_channel;

	modport source (output valid, op, cmd_time, channels, status_channel, input ready);
	modport sink   (input valid, op, cmd_time, channels, status_channel, output ready);
endinterface

interface acfc_result_if import acfc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] fire_lines;
	logic              armed;
	logic              high_rate;
	logic              identify_on;
	logic              time_valid;
	logic              cmd_valid;
	logic [TIME_W-1:0] cmd_count;
	logic [TIME_W-1:0] fire_count;
	logic [TIME_W-1:0] last_fire_time;
	logic [TIME_W-1:0] clock_seconds;

	modport source (output valid, fire_lines, armed, high_rate, identify_on, time_valid,
		cmd_valid, cmd_count, fire_count, last_fire_time, clock_seconds, input ready);
	modport sink   (input valid, fire_lines, armed, high_rate, identify_on, time_valid,
		cmd_valid, cmd_count, fire_count, last_fire_time, clock_seconds, output ready);
endinterface

interface acfc_cfg_if import acfc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/acfc_lane.sv
// one firing channel: pulse timer, fire counter and last fire time stamp
// depends on acfc_pkg; instantiated by armed_channel_firing_controller_core
module acfc_lane import acfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  acfc_lane_ctl_t    ctl,
	output logic              line_nx,
	output logic [TIME_W-1:0] count_nx,
	output logic [TIME_W-1:0] stamp_nx
);

	logic [TICKS_W-1:0] pulse_q, pulse_nx;
	logic [TIME_W-1:0]  count_q;
	logic [TIME_W-1:0]  stamp_q;

	// countdown on ticks, restart and count on fire
	always_comb begin
		pulse_nx = pulse_q;
		count_nx = count_q;
		stamp_nx = stamp_q;
		if (ctl.tick && pulse_q != '0) begin
			pulse_nx = pulse_q - TICKS_W'(1);
		end
		if (ctl.fire) begin
			pulse_nx = ctl.len;
			count_nx = count_q + TIME_W'(1);
			stamp_nx = ctl.stamp;
		end
		// the line is high exactly while its timer runs
		line_nx = (pulse_nx != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= '0;
			count_q <= '0;
			stamp_q <= '0;
		end else begin
			pulse_q <= pulse_nx;
			count_q <= count_nx;
			stamp_q <= stamp_nx;
		end
	end

endmodule

// File: hw/rtl/armed_channel_firing_controller_core.sv
// top level of the armed channel firing controller: seconds clock, command checks,
// arm/rate/identify state and channel lanes; depends on acfc_pkg, acfc_if, acfc_lane
//
//   port    | dir | carries
//   --------+-----+------------------------------------------------------------
//   item    | in  | tick or timestamped command, fire mask, status channel
//   result  | out | line levels, flags, counters, status channel stamp, clock
//   cfg     | in  | register writes: pulse ticks, identify ticks, time window
//
// one item per cycle sustained while the result port is ready; a result is offered once its item
// has passed the input register and then the result register
// a stalled result register holds the input register, which then holds the item port
// reset clears the controller, lane and valid state, sets high rate mode and the register defaults
// register writes complete in the cycle they are presented
module armed_channel_firing_controller_core import acfc_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	acfc_item_if.sink        item,
	acfc_result_if.source    result,
	acfc_cfg_if.sink         cfg
);

	// only mask bits below the line count can ever fire
	localparam int NUM_LANES = (NUM_CHANNELS < MASK_W) ? NUM_CHANNELS : MASK_W;

	// configuration registers
	logic [TICKS_W-1:0] pulse_ticks_q;
	logic [TICKS_W-1:0] ident_ticks_q;
	logic [WIN_W-1:0]   time_window_q;

	// input stage
	logic              valid_s1;
	acfc_op_t          op_s1;
	logic [TIME_W-1:0] time_s1;
	logic [MASK_W-1:0] mask_s1;
	logic [SEL_W-1:0]  sel_s1;

	// controller state
	logic               armed_q;
	logic               clock_set_q;
	logic [TIME_W-1:0]  seconds_q;
	logic [PHASE_W-1:0] phase_q;
	logic [TIME_W-1:0]  cmd_total_q;
	logic               high_rate_q;
	logic [TICKS_W-1:0] ident_rem_q;

	// result register
	logic              res_valid_q;
	logic [MASK_W-1:0] res_lines_q;
	logic              res_armed_q;
	logic              res_high_rate_q;
	logic              res_ident_q;
	logic              res_timely_q;
	logic              res_cmd_valid_q;
	logic [TIME_W-1:0] res_cmd_count_q;
	logic [TIME_W-1:0] res_fire_count_q;
	logic [TIME_W-1:0] res_fire_time_q;
	logic [TIME_W-1:0] res_seconds_q;

	// next-state values
	logic               advance;
	logic               step;
	logic               is_tick;
	logic [TIME_W-1:0]  cmd_clock;
	logic [TIME_W-1:0]  lag;
	logic               timely;
	logic               fire_go;
	logic               armed_nx;
	logic               clock_set_nx;
	logic [TIME_W-1:0]  seconds_nx;
	logic [PHASE_W-1:0] phase_nx;
	logic [TIME_W-1:0]  cmd_total_nx;
	logic               high_rate_nx;
	logic [TICKS_W-1:0] ident_rem_nx;
	logic               timely_out;
	logic               cmd_valid_nx;
	logic [MASK_W-1:0]  lines_nx;
	logic [TIME_W-1:0]  fire_count_sel;
	logic [TIME_W-1:0]  fire_time_sel;

	acfc_lane_ctl_t     lane_ctl   [NUM_LANES];
	logic               lane_line  [NUM_LANES];
	logic [TIME_W-1:0]  lane_count [NUM_LANES];
	logic [TIME_W-1:0]  lane_stamp [NUM_LANES];

	// handshake: the input stage moves whenever the result register is free or draining
	assign advance    = !res_valid_q || result.ready;
	assign step       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	// configuration writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ticks_q <= PULSE_TICKS_RST;
			ident_ticks_q <= IDENT_TICKS_RST;
			time_window_q <= TIME_WINDOW_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PULSE_TICKS: pulse_ticks_q <= cfg.data;
				REG_IDENT_TICKS: ident_ticks_q <= cfg.data;
				REG_TIME_WINDOW: time_window_q <= cfg.data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1   <= acfc_op_t'(item.op);
			time_s1 <= item.cmd_time;
			mask_s1 <= item.channels;
			sel_s1  <= item.status_channel;
		end
	end

	// clock update and timeliness check for a command
	assign is_tick   = (op_s1 == OP_TICK);
	assign cmd_clock = (!clock_set_q || time_s1 > seconds_q) ? time_s1 : seconds_q;
	assign lag       = cmd_clock - time_s1;
	assign timely    = (lag < {{(TIME_W-WIN_W){1'b0}}, time_window_q});
	assign fire_go   = (op_s1 == OP_FIRE) && timely && armed_q;

	// command decode and tick bookkeeping
	always_comb begin
		armed_nx     = armed_q;
		clock_set_nx = clock_set_q;
		seconds_nx   = seconds_q;
		phase_nx     = phase_q;
		cmd_total_nx = cmd_total_q;
		high_rate_nx = high_rate_q;
		ident_rem_nx = ident_rem_q;
		timely_out   = 1'b0;
		cmd_valid_nx = 1'b0;
		if (is_tick) begin
			if (ident_rem_q != '0) begin
				ident_rem_nx = ident_rem_q - TICKS_W'(1);
			end
			if (phase_q == PHASE_LAST) begin
				phase_nx   = '0;
				seconds_nx = seconds_q + TIME_W'(1);
			end else begin
				phase_nx = phase_q + PHASE_W'(1);
			end
		end else begin
			clock_set_nx = 1'b1;
			seconds_nx   = cmd_clock;
			cmd_total_nx = cmd_total_q + TIME_W'(1);
			timely_out   = timely;
			case (op_s1)
				OP_ARM: begin
					if (timely) begin
						armed_nx     = 1'b1;
						cmd_valid_nx = 1'b1;
					end
				end
				OP_DISARM: begin
					armed_nx     = 1'b0;
					cmd_valid_nx = 1'b1;
				end
				OP_RATE_LO: begin
					if (timely) begin
						high_rate_nx = 1'b0;
						cmd_valid_nx = 1'b1;
					end
				end
				OP_RATE_HI: begin
					if (timely) begin
						high_rate_nx = 1'b1;
						cmd_valid_nx = 1'b1;
					end
				end
				OP_IDENTIFY: begin
					ident_rem_nx = at_least_one(ident_ticks_q);
					cmd_valid_nx = 1'b1;
				end
				OP_PING: begin
					cmd_valid_nx = 1'b1;
				end
				OP_FIRE: begin
					cmd_valid_nx = fire_go;
				end
				default: ;
			endcase
		end
	end

	// channel lanes
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		assign lane_ctl[i].tick  = step && is_tick;
		assign lane_ctl[i].fire  = step && fire_go && mask_s1[i];
		assign lane_ctl[i].len   = at_least_one(pulse_ticks_q);
		assign lane_ctl[i].stamp = cmd_clock;

		acfc_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl[i]),
			.line_nx  (lane_line[i]),
			.count_nx (lane_count[i]),
			.stamp_nx (lane_stamp[i])
		);
	end

	// line levels and status channel selection
	always_comb begin
		lines_nx       = '0;
		fire_count_sel = '0;
		fire_time_sel  = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			lines_nx[i] = lane_line[i];
			if (sel_s1 == SEL_W'(i)) begin
				fire_count_sel = lane_count[i];
				fire_time_sel  = lane_stamp[i];
			end
		end
	end

	// controller state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			clock_set_q <= 1'b0;
			seconds_q   <= '0;
			phase_q     <= '0;
			cmd_total_q <= '0;
			high_rate_q <= 1'b1;
			ident_rem_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				armed_q     <= armed_nx;
				clock_set_q <= clock_set_nx;
				seconds_q   <= seconds_nx;
				phase_q     <= phase_nx;
				cmd_total_q <= cmd_total_nx;
				high_rate_q <= high_rate_nx;
				ident_rem_q <= ident_rem_nx;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_lines_q      <= lines_nx;
			res_armed_q      <= armed_nx;
			res_high_rate_q  <= high_rate_nx;
			res_ident_q      <= (ident_rem_nx != '0);
			res_timely_q     <= timely_out;
			res_cmd_valid_q  <= cmd_valid_nx;
			res_cmd_count_q  <= cmd_total_nx;
			res_fire_count_q <= fire_count_sel;
			res_fire_time_q  <= fire_time_sel;
			res_seconds_q    <= seconds_nx;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.fire_lines     = res_lines_q;
	assign result.armed          = res_armed_q;
	assign result.high_rate      = res_high_rate_q;
	assign result.identify_on    = res_ident_q;
	assign result.time_valid     = res_timely_q;
	assign result.cmd_valid      = res_cmd_valid_q;
	assign result.cmd_count      = res_cmd_count_q;
	assign result.fire_count     = res_fire_count_q;
	assign result.last_fire_time = res_fire_time_q;
	assign result.clock_seconds  = res_seconds_q;

endmodule

// File: sim/testbench.sv
// testbench for armed_channel_firing_controller_core: directed table, then random traffic
// in phases with different register settings, checked against pinned rows or an in-bench predictor
// depends on acfc_pkg, acfc_if and the core rtl
module testbench import acfc_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH       = NUM_CHANNELS_DEF;
	localparam int MS_PER_SEC   = 1000;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 80;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_PCT     = 35;

	typedef struct packed {
		acfc_op_t          op;
		logic [TIME_W-1:0] cmd_time;
		logic [MASK_W-1:0] channels;
		logic [SEL_W-1:0]  status_channel;
	} ctl_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] fire_lines;
		logic              armed;
		logic              high_rate;
		logic              identify_on;
		logic              time_valid;
		logic              cmd_valid;
		logic [TIME_W-1:0] cmd_count;
		logic [TIME_W-1:0] fire_count;
		logic [TIME_W-1:0] last_fire_time;
		logic [TIME_W-1:0] clock_seconds;
	} ctl_result_t;

	// a directed row: the item, and a typed-in result where one is pinned
	typedef struct packed {
		ctl_item_t   item;
		logic        pinned;
		ctl_result_t want;
	} dir_row_t;

	typedef struct {
		logic [TICKS_W-1:0] pulse;
		logic [TICKS_W-1:0] ident;
		logic [WIN_W-1:0]   window;
		int                 count;
		int                 tick_pct;
		bit                 steady;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n;

	acfc_item_if   item_bus();
	acfc_result_if result_bus();
	acfc_cfg_if    cfg_bus();

	armed_channel_firing_controller_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	always #6 clk = ~clk;

	// predictor state and register copies
	logic [TICKS_W-1:0] pulse_cfg;
	logic [TICKS_W-1:0] ident_cfg;
	logic [WIN_W-1:0]   window_cfg;
	logic               armed_q;
	logic               clock_set;
	logic [TIME_W-1:0]  secs;
	int unsigned        ms_phase;
	logic [TICKS_W-1:0] pulse_left [NUM_CH];
	logic [MASK_W-1:0]  lines;
	logic [TIME_W-1:0]  fire_cnt [NUM_CH];
	logic [TIME_W-1:0]  fire_stamp [NUM_CH];
	logic [TIME_W-1:0]  cmd_total;
	logic               rate_hi;
	logic [TICKS_W-1:0] ident_left;

	ctl_result_t expected_results [$];
	int          failures = 0;
	int unsigned cycle_count;
	bit          src_steady = 1'b0;
	bit          sink_steady = 1'b0;
	bit          sink_hold = 1'b0;
	bit          pressure_go = 1'b0;

	// directed rows: reset state, timing window edges, arm gating, refire, clock wrap setup
	dir_row_t dir_table [24] = '{
		'{'{OP_TICK, 32'hFFFF_FFFF, 8'hFF, 3'd0}, 1'b1,
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{'{OP_PING, 32'd0, 8'h00, 3'd0}, 1'b1,
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 32'd1, 32'd0, 32'd0, 32'd0}},
		'{'{OP_FIRE, 32'd10, 8'hFF, 3'd7}, 1'b1,
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 32'd2, 32'd0, 32'd0, 32'd10}},
		'{'{OP_ARM, 32'd4, 8'h00, 3'd0}, 1'b1,
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd3, 32'd0, 32'd0, 32'd10}},
		'{'{OP_ARM, 32'd5, 8'h00, 3'd0}, 1'b1,
			'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd4, 32'd0, 32'd0, 32'd10}},
		'{'{OP_ARM, 32'd6, 8'h00, 3'd0}, 1'b0, '0},
		'{'{OP_FIRE, 32'd10, 8'h00, 3'd3}, 1'b0, '0},
		'{'{OP_FIRE, 32'd10, 8'hFF, 3'd7}, 1'b0, '0},
		'{'{OP_FIRE, 32'd11, 8'h01, 3'd0}, 1'b0, '0},
		'{'{OP_TICK, 32'd0, 8'h00, 3'd0}, 1'b0, '0},
		'{'{OP_RATE_LO, 32'd0, 8'h00, 3'd0}, 1'b0, '0},
		'{'{OP_RATE_LO, 32'd11, 8'h00, 3'd7}, 1'b0, '0},
		'{'{OP_IDENTIFY, 32'd0, 8'h00, 3'd0}, 1'b0, '0},
		'{'{OP_DISARM, 32'd0, 8'h00, 3'd1}, 1'b0, '0},
		'{'{OP_FIRE, 32'd11, 8'h80, 3'd7}, 1'b0, '0},
		'{'{OP_RATE_HI, 32'd7, 8'h00, 3'd0}, 1'b0, '0},
		'{'{OP_ARM, 32'hFFFF_FFFF, 8'h00, 3'd0}, 1'b0, '0},
		'{'{OP_FIRE, 32'hFFFF_FFFA, 8'h80, 3'd7}, 1'b0, '0},
		'{'{OP_FIRE, 32'hFFFF_FFFB, 8'hAA, 3'd1}, 1'b0, '0},
		'{'{OP_FIRE, 32'd0, 8'h55, 3'd1}, 1'b0, '0},
		'{'{OP_TICK, 32'd0, 8'h55, 3'd6}, 1'b0, '0},
		'{'{OP_PING, 32'h8000_0000, 8'h00, 3'd2}, 1'b0, '0},
		'{'{OP_IDENTIFY, 32'hFFFF_FFFF, 8'h00, 3'd5}, 1'b0, '0},
		'{'{OP_TICK, 32'hFFFF_FFFF, 8'hFF, 3'd7}, 1'b0, '0}
	};

	// random phases; the first is tick heavy so the clock wraps past all ones
	phase_t phase_plan [6] = '{
		'{16'd1000, 16'd2000, 8'd5, 1300, 85, 1'b0},
		'{16'd1, 16'd1, 8'd1, 200, 50, 1'b0},
		'{16'd0, 16'd0, 8'd0, 150, 50, 1'b0},
		'{16'hFFFF, 16'hFFFF, 8'hFF, 200, 40, 1'b0},
		'{16'd3, 16'd7, 8'd2, 200, 50, 1'b1},
		'{16'd1, 16'd1, 8'd1, 200, 50, 1'b0}
	};

	// predictor reset to the power-on state
	task automatic predictor_reset();
		pulse_cfg  = PULSE_TICKS_RST;
		ident_cfg  = IDENT_TICKS_RST;
		window_cfg = TIME_WINDOW_RST;
		armed_q    = 1'b0;
		clock_set  = 1'b0;
		secs       = '0;
		ms_phase   = 0;
		lines      = '0;
		cmd_total  = '0;
		rate_hi    = 1'b1;
		ident_left = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			pulse_left[i] = '0;
			fire_cnt[i]   = '0;
			fire_stamp[i] = '0;
		end
	endtask

	// advance the predictor by one item and return the expected result
	function automatic ctl_result_t controller_step(input ctl_item_t it);
		ctl_result_t       r;
		logic              timely;
		logic              accepted;
		logic [TICKS_W-1:0] len;
		r        = '0;
		timely   = 1'b0;
		accepted = 1'b0;
		if (it.op == OP_TICK) begin
			// count down line and identify timers, advance the clock
			for (int i = 0; i < NUM_CH; i++) begin
				if (pulse_left[i] != '0) begin
					pulse_left[i] = pulse_left[i] - 1'b1;
					if (pulse_left[i] == '0 && i < MASK_W)
						lines[i] = 1'b0;
				end
			end
			if (ident_left != '0)
				ident_left = ident_left - 1'b1;
			ms_phase++;
			if (ms_phase >= MS_PER_SEC) begin
				ms_phase = 0;
				secs     = secs + 1'b1;
			end
		end else begin
			// first command sets the clock, later ones only move it ahead
			if (!clock_set) begin
				secs      = it.cmd_time;
				clock_set = 1'b1;
			end else if (it.cmd_time > secs) begin
				secs = it.cmd_time;
			end
			timely = (it.cmd_time > secs) || ((secs - it.cmd_time) < {24'd0, window_cfg});
			case (it.op)
				OP_ARM: begin
					if (timely) begin
						armed_q  = 1'b1;
						accepted = 1'b1;
					end
				end
				OP_DISARM: begin
					armed_q  = 1'b0;
					accepted = 1'b1;
				end
				OP_RATE_LO: begin
					if (timely) begin
						rate_hi  = 1'b0;
						accepted = 1'b1;
					end
				end
				OP_RATE_HI: begin
					if (timely) begin
						rate_hi  = 1'b1;
						accepted = 1'b1;
					end
				end
				OP_IDENTIFY: begin
					ident_left = (ident_cfg == '0) ? TICKS_W'(1) : ident_cfg;
					accepted   = 1'b1;
				end
				OP_PING: accepted = 1'b1;
				OP_FIRE: begin
					if (timely && armed_q) begin
						len = (pulse_cfg == '0) ? TICKS_W'(1) : pulse_cfg;
						for (int i = 0; i < NUM_CH && i < MASK_W; i++) begin
							if (it.channels[i]) begin
								lines[i]      = 1'b1;
								pulse_left[i] = len;
								fire_cnt[i]   = fire_cnt[i] + 1'b1;
								fire_stamp[i] = secs;
							end
						end
						accepted = 1'b1;
					end
				end
				default: ;
			endcase
			cmd_total = cmd_total + 1'b1;
		end
		r.fire_lines  = lines;
		r.armed       = armed_q;
		r.high_rate   = rate_hi;
		r.identify_on = (ident_left != '0);
		r.time_valid  = timely;
		r.cmd_valid   = accepted;
		r.cmd_count   = cmd_total;
		if (int'(it.status_channel) < NUM_CH) begin
			r.fire_count     = fire_cnt[it.status_channel];
			r.last_fire_time = fire_stamp[it.status_channel];
		end
		r.clock_seconds = secs;
		return r;
	endfunction

	// random item: commands mostly near the timeliness edge, some anywhere
	function automatic ctl_item_t random_item(input int tick_pct);
		ctl_item_t it;
		it.op = OP_TICK;
		if ($urandom_range(99) >= tick_pct) begin
			case ($urandom_range(9))
				0, 1, 2: it.op = OP_FIRE;
				3, 4:    it.op = OP_ARM;
				5:       it.op = OP_DISARM;
				6:       it.op = OP_RATE_LO;
				7:       it.op = OP_RATE_HI;
				8:       it.op = OP_IDENTIFY;
				default: it.op = OP_PING;
			endcase
		end
		if ($urandom_range(9) < 7)
			it.cmd_time = secs - {24'd0, window_cfg} - 32'd1
				+ 32'($urandom_range(int'(window_cfg) + 3));
		else
			it.cmd_time = $urandom;
		it.channels       = MASK_W'($urandom);
		it.status_channel = SEL_W'($urandom);
		return it;
	endfunction

	// offer one item, wait for the transaction, record what it should produce
	task automatic send_item(input ctl_item_t it, input logic pinned, input ctl_result_t want);
		ctl_result_t predicted;
		while (!src_steady && $urandom_range(99) < IDLE_PCT) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid          <= 1'b1;
		item_bus.op             <= it.op;
		item_bus.cmd_time       <= it.cmd_time;
		item_bus.channels       <= it.channels;
		item_bus.status_channel <= it.status_channel;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		predicted = controller_step(it);
		expected_results.push_back(pinned ? want : predicted);
	endtask

	// one register write; leaves valid high for a back-to-back write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			REG_PULSE_TICKS: pulse_cfg = value;
			REG_IDENT_TICKS: ident_cfg = value;
			REG_TIME_WINDOW: window_cfg = value[WIN_W-1:0];
			default: ;
		endcase
	endtask

	// wait for every outstanding result, then let the block drain
	task automatic settle();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			failures++;
		end
	endtask

	// stimulus: reset, directed table, then random phases
	initial begin : stimulus
		ctl_item_t it;
		arst_n                  = 1'b0;
		item_bus.valid          = 1'b0;
		item_bus.op             = OP_TICK;
		item_bus.cmd_time       = '0;
		item_bus.channels       = '0;
		item_bus.status_channel = '0;
		cfg_bus.valid           = 1'b0;
		cfg_bus.index           = REG_PULSE_TICKS;
		cfg_bus.data            = '0;
		predictor_reset();
		phase_plan[5].pulse  = TICKS_W'($urandom_range(40, 1));
		phase_plan[5].ident  = TICKS_W'($urandom_range(40, 1));
		phase_plan[5].window = WIN_W'($urandom_range(8, 1));
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			send_item(dir_table[i].item, dir_table[i].pinned, dir_table[i].want);

		foreach (phase_plan[p]) begin
			// registers change only with the block drained
			item_bus.valid <= 1'b0;
			settle();
			write_reg(REG_PULSE_TICKS, phase_plan[p].pulse);
			write_reg(REG_IDENT_TICKS, phase_plan[p].ident);
			write_reg(REG_TIME_WINDOW, {8'($urandom), phase_plan[p].window});
			cfg_bus.valid <= 1'b0;
			src_steady  = phase_plan[p].steady;
			sink_steady <= phase_plan[p].steady;
			if (p == 1)
				pressure_go <= 1'b1;
			repeat (phase_plan[p].count) begin
				it = random_item(phase_plan[p].tick_pct);
				send_item(it, 1'b0, '0);
			end
		end

		item_bus.valid <= 1'b0;
		settle();
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// long receiver hold-off so the block backs up into the item port
	initial begin : receiver_holdoff
		int held;
		wait (pressure_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		for (held = 0; held < HOLD_CYCLES; held++)
			@(posedge clk);
		sink_hold <= 1'b0;
	end

	// result side: random ready, compare each transaction with the oldest expectation
	initial begin : result_monitor
		ctl_result_t got;
		ctl_result_t want;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				got.fire_lines     = result_bus.fire_lines;
				got.armed          = result_bus.armed;
				got.high_rate      = result_bus.high_rate;
				got.identify_on    = result_bus.identify_on;
				got.time_valid     = result_bus.time_valid;
				got.cmd_valid      = result_bus.cmd_valid;
				got.cmd_count      = result_bus.cmd_count;
				got.fire_count     = result_bus.fire_count;
				got.last_fire_time = result_bus.last_fire_time;
				got.clock_seconds  = result_bus.clock_seconds;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %p", $time, got);
					failures++;
				end else begin
					want = expected_results.pop_front();
					check_field("fire_lines", 32'(want.fire_lines), 32'(got.fire_lines));
					check_field("armed", 32'(want.armed), 32'(got.armed));
					check_field("high_rate", 32'(want.high_rate), 32'(got.high_rate));
					check_field("identify_on", 32'(want.identify_on), 32'(got.identify_on));
					check_field("time_valid", 32'(want.time_valid), 32'(got.time_valid));
					check_field("cmd_valid", 32'(want.cmd_valid), 32'(got.cmd_valid));
					check_field("cmd_count", want.cmd_count, got.cmd_count);
					check_field("fire_count", want.fire_count, got.fire_count);
					check_field("last_fire_time", want.last_fire_time, got.last_fire_time);
					check_field("clock_seconds", want.clock_seconds, got.clock_seconds);
				end
			end
			result_bus.ready <= !sink_hold && (sink_steady || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// run limit
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule
